// ===== hdl/sbf_pkg.sv =====
// sbf_pkg: shared widths, reset values and register indexes for the
// spectral band feature block. No dependencies.
package sbf_pkg;

   localparam int POWER_W = 32;
   localparam int ACC_W = 44;
   localparam int COUNT_W = 13;
   localparam int FRAC_W = 17;
   localparam int RATIO_W = 17;
   localparam int CREST_W = 32;
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int CREST_PROD_W = 45;
   localparam int DIV_NUM_W = 61;
   localparam int DIV_DEN_W = 44;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int CSR_INDEX_W = 2;

   localparam int MAX_BINS_DEFAULT = 4096;
   localparam int POWER_BITS_DEFAULT = 32;

   localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = 13'd1024;
   localparam logic [FRAC_W-1:0] LOW_FRACTION_RESET = 17'd6554;
   localparam logic [FRAC_W-1:0] HIGH_FRACTION_RESET = 17'd58982;
   localparam logic [FRAC_W-1:0] Q16_ONE = 17'h10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = 2'd2;

endpackage

// ===== hdl/sbf_divider.sv =====
// sbf_divider: restoring divider, one quotient bit per cycle.
// Depends on sbf_pkg for the operand widths.
module sbf_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sbf_pkg::DIV_NUM_W-1:0] numerator,
   input  logic [sbf_pkg::DIV_DEN_W-1:0] denominator,
   output logic                          done,
   output logic [sbf_pkg::DIV_NUM_W-1:0] quotient
);
   import sbf_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] rem_ff;

   logic [DIV_DEN_W:0]   trial;
   logic                 fits;
   logic [DIV_DEN_W:0]   rem_in;

   // shift the next numerator bit into the partial remainder
   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign fits = trial >= {1'b0, den_ff};
   assign rem_in = fits ? (trial - {1'b0, den_ff}) : trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == DIV_CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            count_ff <= DIV_CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - DIV_CNT_W'(1);
            if (count_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         den_ff <= denominator;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[DIV_NUM_W-2:0], fits};
         rem_ff <= rem_in[DIV_DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quotient = num_ff;

endmodule

// ===== hdl/spectral_band_features.sv =====
// spectral_band_features: per-frame band energy ratios and spectral crest.
// Depends on sbf_pkg and sbf_divider.
// Each bin goes through the transfer, two passes of the shared 32x17
// multiplier for the crest range bounds, and the accumulate step.
// After the last bin of a frame: the crest product is registered, then five
// divisions run on one shared divider, then the result is registered once the
// result register is free. Reset is synchronous: it clears the accumulators,
// the sequencer and the result valid flag and reloads the config defaults.
module spectral_band_features #(
   parameter int MAX_BINS = sbf_pkg::MAX_BINS_DEFAULT,
   parameter int POWER_BITS = sbf_pkg::POWER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sbf_pkg::POWER_W-1:0]     req_bin_power,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sbf_pkg::ACC_W-1:0]       rsp_volume,
   output logic [sbf_pkg::RATIO_W-1:0]     rsp_band_ratio_0,
   output logic [sbf_pkg::RATIO_W-1:0]     rsp_band_ratio_1,
   output logic [sbf_pkg::RATIO_W-1:0]     rsp_band_ratio_2,
   output logic [sbf_pkg::RATIO_W-1:0]     rsp_band_ratio_3,
   output logic [sbf_pkg::CREST_W-1:0]     rsp_crest_factor,
   output logic                            rsp_bands_valid,
   output logic                            rsp_crest_valid,
   input  logic                            csr_write_enable,
   input  logic [sbf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbf_pkg::FRAC_W-1:0]      csr_write_data
);
   import sbf_pkg::*;

   localparam logic [POWER_W-1:0] POWER_MASK = (POWER_BITS >= POWER_W) ? '1 :
      POWER_W'((64'd1 << POWER_BITS) - 64'd1);
   localparam logic [COUNT_W-1:0] MAX_N = (MAX_BINS >= (1 << COUNT_W)) ? '1 :
      COUNT_W'(MAX_BINS);
   localparam logic [ACC_W-1:0] ACC_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOW,
      ST_HIGH,
      ST_ACC,
      ST_CREST,
      ST_DIV,
      ST_WAIT,
      ST_EMIT
   } state_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [POWER_W-1:0] v);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {{(ACC_W + 1 - POWER_W){1'b0}}, v};
      return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   endfunction

   // configuration registers
   logic [COUNT_W-1:0] bin_count_ff;
   logic [FRAC_W-1:0]  low_fraction_ff;
   logic [FRAC_W-1:0]  high_fraction_ff;

   // sequencer and per-bin working registers
   state_type          state_ff;
   logic [COUNT_W-1:0] n_ff;
   logic [FRAC_W-1:0]  low_ff;
   logic [FRAC_W-1:0]  high_ff;
   logic [POWER_W-1:0] power_ff;
   logic [COUNT_W-1:0] start_ff;
   logic [COUNT_W-1:0] end_ff;
   logic [2:0]         div_sel_ff;

   // frame accumulators
   logic [COUNT_W-1:0] position_ff;
   logic [ACC_W-1:0]   total_ff;
   logic [ACC_W-1:0]   band_ff [4];
   logic [ACC_W-1:0]   range_sum_ff;
   logic [POWER_W-1:0] range_max_ff;

   logic [CREST_PROD_W-1:0] crest_prod_ff;
   logic [RATIO_W-1:0]      ratio_ff [4];
   logic [CREST_W-1:0]      crest_ff;

   // result register
   logic                rsp_valid_ff;
   logic [ACC_W-1:0]    rsp_volume_ff;
   logic [RATIO_W-1:0]  rsp_ratio_ff [4];
   logic [CREST_W-1:0]  rsp_crest_ff;
   logic                rsp_bands_valid_ff;
   logic                rsp_crest_valid_ff;

   logic [COUNT_W-1:0]   n_in;
   logic [FRAC_W-1:0]    low_in;
   logic [FRAC_W-1:0]    high_in;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   mul_p;
   logic [30:0]          round_sum;
   logic [COUNT_W-1:0]   bound_in;
   logic [1:0]           band_sel;
   logic                 in_range;
   logic                 last_bin;
   logic                 bands_ok;
   logic                 crest_ok;
   logic                 div_start;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_q;
   logic [RATIO_W-1:0]   ratio_in;
   logic [CREST_W-1:0]   crest_in;
   logic                 emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= BIN_COUNT_RESET;
         low_fraction_ff <= LOW_FRACTION_RESET;
         high_fraction_ff <= HIGH_FRACTION_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIN_COUNT: bin_count_ff <= csr_write_data[COUNT_W-1:0];
            CSR_RANGE_LOW: low_fraction_ff <= csr_write_data;
            CSR_RANGE_HIGH: high_fraction_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (bin_count_ff == '0) begin
         n_in = COUNT_W'(1);
      end else if (bin_count_ff > MAX_N) begin
         n_in = MAX_N;
      end else begin
         n_in = bin_count_ff;
      end
   end

   assign low_in = (low_fraction_ff > Q16_ONE) ? Q16_ONE : low_fraction_ff;
   assign high_in = (high_fraction_ff > Q16_ONE) ? Q16_ONE : high_fraction_ff;

   // shared multiplier: range bounds, then the crest numerator
   always_comb begin
      case (state_ff)
         ST_LOW: begin
            mul_a = {{(MUL_A_W - COUNT_W){1'b0}}, n_ff};
            mul_b = low_ff;
         end
         ST_HIGH: begin
            mul_a = {{(MUL_A_W - COUNT_W){1'b0}}, n_ff};
            mul_b = high_ff;
         end
         default: begin
            mul_a = range_max_ff;
            mul_b = {{(MUL_B_W - COUNT_W){1'b0}}, end_ff - start_ff};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   // round half up: n*frac fits in 30 bits, the bound never exceeds n
   assign round_sum = mul_p[30:0] + 31'h8000;
   assign bound_in = round_sum[16+COUNT_W-1:16];

   always_comb begin
      if (position_ff < (n_ff >> 3)) begin
         band_sel = 2'd0;
      end else if (position_ff < (n_ff >> 2)) begin
         band_sel = 2'd1;
      end else if (position_ff < (n_ff >> 1)) begin
         band_sel = 2'd2;
      end else begin
         band_sel = 2'd3;
      end
   end

   assign in_range = (position_ff >= start_ff) && (position_ff < end_ff);
   assign last_bin = ({1'b0, position_ff} + (COUNT_W + 1)'(1)) >= {1'b0, n_ff};
   assign bands_ok = (n_ff >= COUNT_W'(8)) && (total_ff != '0);
   assign crest_ok = (end_ff > start_ff) && (range_sum_ff != '0);

   always_comb begin
      if (div_sel_ff == 3'd4) begin
         div_num = {crest_prod_ff, 16'h0000};
         div_den = range_sum_ff;
      end else begin
         div_num = {1'b0, band_ff[div_sel_ff[1:0]], 16'h0000}
                   + {{(DIV_NUM_W - ACC_W + 1){1'b0}}, total_ff[ACC_W-1:1]};
         div_den = total_ff;
      end
   end

   assign div_start = (state_ff == ST_DIV);

   sbf_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_q)
   );

   assign ratio_in = (div_q > {{(DIV_NUM_W - RATIO_W){1'b0}}, Q16_ONE}) ?
      Q16_ONE : div_q[RATIO_W-1:0];
   assign crest_in = (div_q[DIV_NUM_W-1:CREST_W] != '0) ? '1 : div_q[CREST_W-1:0];

   // the result register may still hold the previous frame
   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_sel_ff <= '0;
         position_ff <= '0;
         total_ff <= '0;
         for (int k = 0; k < 4; k++) begin
            band_ff[k] <= '0;
         end
         range_sum_ff <= '0;
         range_max_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOW;
               end
            end
            ST_LOW: begin
               state_ff <= ST_HIGH;
            end
            ST_HIGH: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               total_ff <= sat_add(total_ff, power_ff);
               for (int k = 0; k < 4; k++) begin
                  if (band_sel == 2'(k)) begin
                     band_ff[k] <= sat_add(band_ff[k], power_ff);
                  end
               end
               if (in_range) begin
                  range_sum_ff <= sat_add(range_sum_ff, power_ff);
                  if (power_ff > range_max_ff) begin
                     range_max_ff <= power_ff;
                  end
               end
               if (last_bin) begin
                  state_ff <= ST_CREST;
               end else begin
                  position_ff <= position_ff + COUNT_W'(1);
                  state_ff <= ST_IDLE;
               end
            end
            ST_CREST: begin
               div_sel_ff <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (div_done) begin
                  if (div_sel_ff == 3'd4) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     div_sel_ff <= div_sel_ff + 3'd1;
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_EMIT: begin
               if (emit) begin
                  position_ff <= '0;
                  total_ff <= '0;
                  for (int k = 0; k < 4; k++) begin
                     band_ff[k] <= '0;
                  end
                  range_sum_ff <= '0;
                  range_max_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         power_ff <= req_bin_power & POWER_MASK;
         n_ff <= n_in;
         low_ff <= low_in;
         high_ff <= high_in;
      end
      if (state_ff == ST_LOW) begin
         start_ff <= bound_in;
      end
      if (state_ff == ST_HIGH) begin
         end_ff <= bound_in;
      end
      if (state_ff == ST_CREST) begin
         crest_prod_ff <= mul_p[CREST_PROD_W-1:0];
      end
      if ((state_ff == ST_WAIT) && div_done) begin
         for (int k = 0; k < 4; k++) begin
            if (div_sel_ff == 3'(k)) begin
               ratio_ff[k] <= ratio_in;
            end
         end
         if (div_sel_ff == 3'd4) begin
            crest_ff <= crest_in;
         end
      end
      if (emit) begin
         rsp_volume_ff <= total_ff;
         for (int k = 0; k < 4; k++) begin
            rsp_ratio_ff[k] <= bands_ok ? ratio_ff[k] : '0;
         end
         rsp_crest_ff <= crest_ok ? crest_ff : '0;
         rsp_bands_valid_ff <= bands_ok;
         rsp_crest_valid_ff <= crest_ok;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_volume = rsp_volume_ff;
   assign rsp_band_ratio_0 = rsp_ratio_ff[0];
   assign rsp_band_ratio_1 = rsp_ratio_ff[1];
   assign rsp_band_ratio_2 = rsp_ratio_ff[2];
   assign rsp_band_ratio_3 = rsp_ratio_ff[3];
   assign rsp_crest_factor = rsp_crest_ff;
   assign rsp_bands_valid = rsp_bands_valid_ff;
   assign rsp_crest_valid = rsp_crest_valid_ff;

`ifndef SYNTHESIS
   // one bin at a time: no back-to-back transfers on the request side
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a bin was in flight");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bands_valid) |-> ((rsp_band_ratio_0 == '0) &&
      (rsp_band_ratio_1 == '0) && (rsp_band_ratio_2 == '0) &&
      (rsp_band_ratio_3 == '0)))
      else $error("band ratio nonzero with bands flagged invalid");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_crest_valid) |-> (rsp_crest_factor == '0))
      else $error("crest nonzero with crest flagged invalid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_band_ratio_0 <= Q16_ONE) && (rsp_band_ratio_1 <= Q16_ONE) &&
      (rsp_band_ratio_2 <= Q16_ONE) && (rsp_band_ratio_3 <= Q16_ONE)))
      else $error("band ratio above one");
`endif

endmodule
